// ===== rtl/aurt_pkg.sv =====
// ============================================================================
// aurt_pkg
// Shared types and constants for the angle unwrap and rate tracker.
// ============================================================================
package aurt_pkg;

    localparam int CordicSteps = 16;
    localparam int StepW       = 4;
    localparam int CordW       = 24;

    // CORDIC arctangent table in binary angle units (65536 per turn)
    function automatic logic [13:0] atan_lut(input logic [StepW-1:0] idx);
        logic [13:0] v;
        unique case (idx)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // capture input transfer, set up CORDIC
        logic iter;     // one CORDIC micro-rotation
        logic unwrap;   // unwrap, rate multiply, history update
        logic div_init; // start average division
        logic div_step; // one restoring division bit
        logic finish;   // sign fix of average, prediction
        logic ease_mul; // easing multiply
        logic commit;   // write result register, update state
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic first;    // this item is a first detection
    } t_stat;

    localparam logic [0:0] RegFrameRate  = 1'd0;
    localparam logic [0:0] RegEaseWeight = 1'd1;

endpackage

// ===== rtl/aurt_ctrl.sv =====
// ============================================================================
// aurt_ctrl
// Sequencer: load, CORDIC iterations, unwrap, average division, easing.
// ============================================================================
module aurt_ctrl #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  logic            i_out_busy,
    input  aurt_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output aurt_pkg::t_cmd  o_cmd
);
    import aurt_pkg::*;

    // one divider step per magnitude bit of the history sum
    localparam int DivW = 23 + $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CORDIC, S_UNWRAP, S_DIV, S_FINISH, S_EASE, S_COMMIT
    } t_state;

    t_state            r_state, n_state;
    logic [4:0]        r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = i_in_fire;
        o_cmd.iter     = (r_state == S_CORDIC);
        o_cmd.unwrap   = (r_state == S_UNWRAP);
        o_cmd.div_init = (r_state == S_UNWRAP);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.finish   = (r_state == S_FINISH);
        o_cmd.ease_mul = (r_state == S_EASE);
        o_cmd.commit   = (r_state == S_COMMIT) && !i_out_busy;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    n_state = S_CORDIC;
                    n_cnt   = '0;
                end
            end
            S_CORDIC: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(CordicSteps - 1)) n_state = S_UNWRAP;
            end
            S_UNWRAP: begin
                n_cnt   = '0;
                n_state = i_stat.first ? S_FINISH : S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(DivW - 1)) n_state = S_FINISH;
            end
            S_FINISH: n_state = S_EASE;
            S_EASE:   n_state = S_COMMIT;
            S_COMMIT: begin
                if (!i_out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/aurt_dp.sv =====
// ============================================================================
// aurt_dp
// Datapath: CORDIC, unwrap, rate history, serial divider, easing.
// ============================================================================
module aurt_dp #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  aurt_pkg::t_cmd        i_cmd,
    output aurt_pkg::t_stat       o_stat,
    input  logic [15:0]           i_point_x,
    input  logic [15:0]           i_point_y,
    input  logic [15:0]           i_pivot_x,
    input  logic [15:0]           i_pivot_y,
    input  logic                  i_restart,
    input  logic [7:0]            i_frame_rate,
    input  logic [8:0]            i_ease_weight,
    output logic [31:0]           o_cont,
    output logic [23:0]           o_rate,
    output logic [23:0]           o_smooth,
    output logic [31:0]           o_ahead
);
    import aurt_pkg::*;

    localparam int SlotW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CntW  = $clog2(HISTORY_DEPTH + 1);
    localparam int SumW  = 24 + $clog2(HISTORY_DEPTH + 1);
    localparam int DivW  = SumW - 1;

    // cordic registers
    logic signed [CordW-1:0] r_x, r_y;
    logic signed [16:0]      r_z;
    logic [StepW-1:0]        r_i;
    logic                    r_zero, r_restart;

    // tracker state
    logic [31:0]             r_last_angle, r_last_ahead;
    logic                    r_first_pending, r_ahead_pending;
    logic signed [23:0]      r_hist [HISTORY_DEPTH];
    logic [SlotW-1:0]        r_slot;
    logic [CntW-1:0]         r_count;
    logic signed [SumW-1:0]  r_sum;
    logic signed [23:0]      r_smooth;

    // per-item work registers
    logic [31:0]             r_cont;
    logic signed [23:0]      r_rate;
    logic                    r_first_item;
    logic [DivW-1:0]         r_quo, r_rem;
    logic                    r_neg;
    logic [31:0]             r_pred;
    logic signed [41:0]      r_prod;

    logic first_now;
    assign first_now = r_first_pending || r_restart;
    assign o_stat.first = first_now;

    // input differences and quadrant pre-rotation
    logic signed [16:0] dx, dy;
    logic signed [CordW-1:0] x0, y0;
    assign dx = $signed({1'b0, i_point_x}) - $signed({1'b0, i_pivot_x});
    assign dy = $signed({1'b0, i_point_y}) - $signed({1'b0, i_pivot_y});
    assign x0 = CordW'(dx) <<< 4;
    assign y0 = CordW'(dy) <<< 4;

    // one micro-rotation
    logic signed [CordW-1:0] xs, ys;
    logic signed [16:0]      at;
    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign at = $signed({3'b000, atan_lut(r_i)});

    // unwrap
    logic [15:0]        raw16, delta16;
    logic signed [31:0] delta;
    logic signed [31:0] rate_full;
    logic signed [23:0] rate_new;
    logic signed [23:0] old_entry;
    logic signed [SumW-1:0] sum_new;
    assign raw16     = r_zero ? 16'd0 : r_z[15:0];
    assign delta16   = raw16 - r_last_angle[15:0];
    assign delta     = 32'($signed(delta16));
    assign rate_full = delta * $signed({24'd0, i_frame_rate});
    assign rate_new  = rate_full[23:0];
    assign old_entry = r_hist[r_slot];
    assign sum_new   = r_sum + SumW'(rate_new)
                     - ((r_count >= CntW'(HISTORY_DEPTH)) ? SumW'(old_entry) : '0);

    // division trial
    logic [DivW:0] trial;
    assign trial = {r_rem, r_quo[DivW-1]} - {{(DivW+1-CntW){1'b0}}, r_count};

    // easing
    logic [8:0]         w;
    logic signed [31:0] d;
    logic signed [41:0] stepv;
    logic [23:0]        q24;
    assign w     = (i_ease_weight > 9'd256) ? 9'd256 : i_ease_weight;
    assign d     = $signed(r_pred - r_last_ahead);
    assign stepv = (r_prod + 42'sd128) >>> 8;
    assign q24   = r_neg ? 24'(-r_quo) : r_quo[23:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle    <= '0;
            r_first_pending <= 1'b1;
            r_slot          <= '0;
            r_count         <= '0;
            r_sum           <= '0;
            r_smooth        <= '0;
            r_last_ahead    <= '0;
            r_ahead_pending <= 1'b1;
            for (int k = 0; k < HISTORY_DEPTH; k++) r_hist[k] <= '0;
        end else begin
            if (i_cmd.load) begin
                r_restart <= i_restart;
                r_zero    <= (dx == 17'sd0) && (dy == 17'sd0);
                r_i       <= '0;
                if (dx < 0) begin
                    if (dy >= 0) begin
                        r_x <= y0; r_y <= -x0; r_z <= 17'sd16384;
                    end else begin
                        r_x <= -y0; r_y <= x0; r_z <= -17'sd16384;
                    end
                end else begin
                    r_x <= x0; r_y <= y0; r_z <= '0;
                end
            end
            if (i_cmd.iter) begin
                r_i <= r_i + 1'b1;
                if (r_y >= 0) begin
                    r_x <= r_x + ys; r_y <= r_y - xs; r_z <= r_z + at;
                end else begin
                    r_x <= r_x - ys; r_y <= r_y + xs; r_z <= r_z - at;
                end
            end
            if (i_cmd.unwrap) begin
                r_first_item <= first_now;
                if (first_now) begin
                    r_cont          <= 32'($signed(raw16));
                    r_rate          <= '0;
                    r_slot          <= '0;
                    r_count         <= '0;
                    r_sum           <= '0;
                    r_smooth        <= '0;
                    r_first_pending <= 1'b0;
                    for (int k = 0; k < HISTORY_DEPTH; k++) r_hist[k] <= '0;
                end else begin
                    r_cont         <= r_last_angle + delta;
                    r_rate         <= rate_new;
                    r_hist[r_slot] <= rate_new;
                    r_sum          <= sum_new;
                    if (r_count < CntW'(HISTORY_DEPTH)) r_count <= r_count + 1'b1;
                    r_slot <= (r_slot == SlotW'(HISTORY_DEPTH - 1)) ? '0
                                                                   : r_slot + 1'b1;
                end
            end
            if (i_cmd.div_init) begin
                r_neg <= sum_new[SumW-1];
                r_quo <= sum_new[SumW-1] ? DivW'(-sum_new) : DivW'(sum_new);
                r_rem <= '0;
            end
            if (i_cmd.div_step) begin
                if (!trial[DivW]) begin
                    r_rem <= trial[DivW-1:0];
                    r_quo <= {r_quo[DivW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[DivW-2:0], r_quo[DivW-1]};
                    r_quo <= {r_quo[DivW-2:0], 1'b0};
                end
            end
            if (i_cmd.finish) begin
                if (!r_first_item) begin
                    r_smooth <= $signed(q24);
                    r_pred   <= r_cont + 32'($signed(q24));
                end else begin
                    r_pred   <= r_cont;
                end
            end
            if (i_cmd.ease_mul) r_prod <= d * $signed({1'b0, w});
            if (i_cmd.commit) begin
                r_last_angle <= r_cont;
                if (r_ahead_pending) begin
                    r_last_ahead    <= r_pred;
                    r_ahead_pending <= 1'b0;
                    o_ahead         <= r_pred;
                end else begin
                    r_last_ahead <= r_last_ahead + stepv[31:0];
                    o_ahead      <= r_last_ahead + stepv[31:0];
                end
                o_cont   <= r_cont;
                o_rate   <= r_rate;
                o_smooth <= r_smooth;
            end
        end
    end

endmodule

// ===== rtl/angle_unwrap_rate_tracker.sv =====
// ============================================================================
// angle_unwrap_rate_tracker
// CORDIC polar angle, phase unwrap, moving-average rate and eased prediction.
// ============================================================================
//  channel  | dir | contents
//  s_axis   | in  | point_x, point_y, pivot_x, pivot_y / tuser restart
//  m_axis   | out | continuous_angle, rate, smooth_rate, ahead_angle
//  apb      | in  | 0x0 frame_rate, 0x4 ease_weight
//
// One item runs through the 16-step CORDIC loop and, except after a first
// detection, the bit-serial average divider (27 steps at the default history
// depth).
// The next item is taken once the result is in the output register.
// Reset is synchronous; there is no clearing pass.
// A stalled output holds the result and blocks the following commit.
module angle_unwrap_rate_tracker #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_x[15:0], point_y[31:16], pivot_x[47:32], pivot_y[63:48]
    input  logic [63:0]  s_axis_tdata,
    // restart[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // continuous_angle[31:0], rate[55:32], smooth_rate[79:56], ahead_angle[111:80]
    output logic [111:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import aurt_pkg::*;

    logic [7:0] r_frame_rate;
    logic [8:0] r_ease_weight;
    logic       r_out_valid;
    t_cmd       cmd;
    t_stat      stat;
    logic       in_fire;
    logic [31:0] cont, ahead;
    logic [23:0] rate, smooth;

    assign pready  = 1'b1;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rate  <= 8'd30;
            r_ease_weight <= 9'd179;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == RegFrameRate)  r_frame_rate  <= pwdata[7:0];
            if (paddr[2] == RegEaseWeight) r_ease_weight <= pwdata[8:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == RegFrameRate) prdata = {24'd0, r_frame_rate};
        else                          prdata = {23'd0, r_ease_weight};
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (cmd.commit) r_out_valid <= 1'b1;
        else if (m_axis_tready) r_out_valid <= 1'b0;
    end
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {ahead, smooth, rate, cont};

    aurt_ctrl #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_busy (r_out_valid && !m_axis_tready),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    aurt_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_point_x     (s_axis_tdata[15:0]),
        .i_point_y     (s_axis_tdata[31:16]),
        .i_pivot_x     (s_axis_tdata[47:32]),
        .i_pivot_y     (s_axis_tdata[63:48]),
        .i_restart     (s_axis_tuser[0]),
        .i_frame_rate  (r_frame_rate),
        .i_ease_weight (r_ease_weight),
        .o_cont        (cont),
        .o_rate        (rate),
        .o_smooth      (smooth),
        .o_ahead       (ahead)
    );

    // a commit never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !(r_out_valid && !m_axis_tready))
        else $error("commit over pending result");

    // no new transfer while a result is pending commit
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !s_axis_tready)
        else $error("second item accepted while busy");

    // a commit raises output valid
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> m_axis_tvalid)
        else $error("result not presented");

endmodule
